// ----- hw/rtl/hcd_pkg.sv -----
package hcd_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL          = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_THRESHOLD = 2'd2;

  // Crossing class of one sample pair. At most one member is set.
  typedef struct packed {
    logic up_low;
    logic up_high;
    logic up_full;
    logic dn_low;
    logic dn_high;
    logic dn_full;
  } xing_t;

endpackage

// ----- hw/rtl/hysteresis_crossing_detector_top.sv -----
// Hysteresis level-crossing detector. Signed samples enter on the in_ channel
// and each sample is compared with the one before it against the low and high
// thresholds; rising and falling trackers take turns, and every confirmed edge
// leaves one item on the out_ channel carrying its direction, the record index
// of the sample closest to the centre level, and that sample's value. A sample
// with in_record_start set, or the first sample after reset, opens a new record
// at index zero and produces no item. The block takes one item per clock while
// in_stall is low: a sample is held in the input register and then passes
// through the classifier and the tracker update into the output register, so
// throughput is one item per cycle unless out_stall holds the output register.
// in_stall rises only while the output register holds an item that is itself
// stalled. The three configuration registers, the level and the two
// thresholds, are written through the cfg_ port, which is always ready; write
// them only while no item is in flight.
module hysteresis_crossing_detector_top #(
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Sample channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_record_start,
  // Edge channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_rising,
  output logic [INDEX_BITS-1:0]         out_edge_index,
  output logic signed [SAMPLE_BITS-1:0] out_edge_value,
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hcd_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [SAMPLE_BITS-1:0]        cfg_data
);
  import hcd_pkg::*;

  // Configuration registers.
  logic signed [SAMPLE_BITS-1:0] level_r;
  logic signed [SAMPLE_BITS-1:0] low_thr_r;
  logic signed [SAMPLE_BITS-1:0] high_thr_r;

  // Input register stage.
  logic                          s1_valid_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic                          s1_start_r;

  // Output register stage.
  logic                          out_valid_r;
  logic                          out_rising_r;
  logic [INDEX_BITS-1:0]         out_index_r;
  logic signed [SAMPLE_BITS-1:0] out_value_r;

  logic                          out_free;
  logic                          s1_go;
  logic                          in_take;
  logic signed [SAMPLE_BITS-1:0] prev_sample;
  xing_t                         xing;
  logic                          hit;
  logic                          hit_rising;
  logic [INDEX_BITS-1:0]         hit_index;
  logic signed [SAMPLE_BITS-1:0] hit_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= '0;
      low_thr_r  <= '0;
      high_thr_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEVEL:          level_r    <= cfg_data;
        CFG_LOW_THRESHOLD:  low_thr_r  <= cfg_data;
        CFG_HIGH_THRESHOLD: high_thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The held sample moves on whenever the output register can take a result.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample_r <= in_sample;
      s1_start_r  <= in_record_start;
    end
  end

  hcd_classify #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_classify (
    .sample_i   (s1_sample_r),
    .prev_i     (prev_sample),
    .low_thr_i  (low_thr_r),
    .high_thr_i (high_thr_r),
    .xing_o     (xing)
  );

  hcd_tracker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_tracker (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_i       (s1_go),
    .sample_i     (s1_sample_r),
    .start_i      (s1_start_r),
    .level_i      (level_r),
    .xing_i       (xing),
    .prev_o       (prev_sample),
    .hit_o        (hit),
    .rising_o     (hit_rising),
    .edge_index_o (hit_index),
    .edge_value_o (hit_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_go && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && hit) begin
      out_rising_r <= hit_rising;
      out_index_r  <= hit_index;
      out_value_r  <= hit_value;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_rising     = out_rising_r;
  assign out_edge_index = out_index_r;
  assign out_edge_value = out_value_r;

endmodule

// ----- hw/rtl/hcd_classify.sv -----
module hcd_classify #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] prev_i,
  input  logic signed [SAMPLE_BITS-1:0] low_thr_i,
  input  logic signed [SAMPLE_BITS-1:0] high_thr_i,
  output hcd_pkg::xing_t                xing_o
);
  import hcd_pkg::*;

  logic up;
  logic dn;
  logic up_lo;
  logic up_hi;
  logic dn_lo;
  logic dn_hi;

  assign up = sample_i > prev_i;
  assign dn = sample_i < prev_i;

  // A threshold is crossed when it lies within the closed span of the pair.
  assign up_lo = up && (prev_i <= low_thr_i) && (sample_i >= low_thr_i);
  assign up_hi = up && (prev_i <= high_thr_i) && (sample_i >= high_thr_i);
  assign dn_lo = dn && (prev_i >= low_thr_i) && (sample_i <= low_thr_i);
  assign dn_hi = dn && (prev_i >= high_thr_i) && (sample_i <= high_thr_i);

  always_comb begin
    xing_o.up_low  = up_lo && !up_hi;
    xing_o.up_high = up_hi && !up_lo;
    xing_o.up_full = up_lo && up_hi;
    xing_o.dn_low  = dn_lo && !dn_hi;
    xing_o.dn_high = dn_hi && !dn_lo;
    xing_o.dn_full = dn_lo && dn_hi;
  end

endmodule

// ----- hw/rtl/hcd_tracker.sv -----
module hcd_tracker #(
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          start_i,
  input  logic signed [SAMPLE_BITS-1:0] level_i,
  input  hcd_pkg::xing_t                xing_i,
  output logic signed [SAMPLE_BITS-1:0] prev_o,
  output logic                          hit_o,
  output logic                          rising_o,
  output logic [INDEX_BITS-1:0]         edge_index_o,
  output logic signed [SAMPLE_BITS-1:0] edge_value_o
);
  import hcd_pkg::*;

  localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

  logic signed [SAMPLE_BITS-1:0] prev_r,  prev_nxt;
  logic                          have_r,  have_nxt;
  logic [INDEX_BITS-1:0]         idx_r,   idx_nxt;
  logic                          rb_r,    rb_nxt;
  logic                          fb_r,    fb_nxt;
  logic                          rf_r,    rf_nxt;
  logic                          ff_r,    ff_nxt;
  logic [INDEX_BITS-1:0]         rpi_r,   rpi_nxt;
  logic signed [SAMPLE_BITS-1:0] rpv_r,   rpv_nxt;
  logic [INDEX_BITS-1:0]         fpi_r,   fpi_nxt;
  logic signed [SAMPLE_BITS-1:0] fpv_r,   fpv_nxt;

  logic [INDEX_BITS-1:0]         cur_idx;
  logic [SAMPLE_BITS:0]          d_prev;
  logic [SAMPLE_BITS:0]          d_cur;
  logic [SAMPLE_BITS:0]          d_rpt;
  logic [SAMPLE_BITS:0]          d_fpt;
  logic [INDEX_BITS-1:0]         c_idx;
  logic signed [SAMPLE_BITS-1:0] c_val;
  logic [SAMPLE_BITS:0]          c_dist;
  logic                          rb_upd;
  logic                          fb_upd;
  logic                          r_hit;
  logic                          f_hit;
  logic                          restart;

  function automatic logic [SAMPLE_BITS:0] dist_f(
    input logic signed [SAMPLE_BITS-1:0] v,
    input logic signed [SAMPLE_BITS-1:0] lvl
  );
    logic signed [SAMPLE_BITS:0] d;
    d = {v[SAMPLE_BITS-1], v} - {lvl[SAMPLE_BITS-1], lvl};
    dist_f = d[SAMPLE_BITS] ? $unsigned(-d) : $unsigned(d);
  endfunction

  assign restart = start_i || !have_r;
  assign cur_idx = (idx_r == IDX_MAX) ? idx_r : idx_r + 1'b1;

  assign d_prev = dist_f(prev_r, level_i);
  assign d_cur  = dist_f(sample_i, level_i);
  assign d_rpt  = dist_f(rpv_r, level_i);
  assign d_fpt  = dist_f(fpv_r, level_i);

  // The closer of the pair wins; a tie goes to the current sample.
  always_comb begin
    if (d_prev < d_cur) begin
      c_idx  = idx_r;
      c_val  = prev_r;
      c_dist = d_prev;
    end else begin
      c_idx  = cur_idx;
      c_val  = sample_i;
      c_dist = d_cur;
    end
  end

  // Tracker flags after this pair; a found tracker holds its state.
  assign rb_upd = xing_i.up_low || (rb_r && !(xing_i.up_high || xing_i.dn_low));
  assign fb_upd = xing_i.dn_high || (fb_r && !(xing_i.dn_low || xing_i.up_high));
  assign r_hit  = !rf_r && ((xing_i.up_high && rb_r) || xing_i.up_full);
  assign f_hit  = !ff_r && ((xing_i.dn_low && fb_r) || xing_i.dn_full);

  always_comb begin
    prev_nxt = sample_i;
    have_nxt = 1'b1;
    idx_nxt  = cur_idx;
    rb_nxt   = rb_r;
    fb_nxt   = fb_r;
    rf_nxt   = rf_r;
    ff_nxt   = ff_r;
    rpi_nxt  = rpi_r;
    rpv_nxt  = rpv_r;
    fpi_nxt  = fpi_r;
    fpv_nxt  = fpv_r;
    if (restart) begin
      idx_nxt = '0;
      rb_nxt  = 1'b0;
      fb_nxt  = 1'b0;
      rf_nxt  = 1'b0;
      ff_nxt  = 1'b0;
      rpi_nxt = '0;
      rpv_nxt = '0;
      fpi_nxt = '0;
      fpv_nxt = '0;
    end else begin
      // Trackers already between the thresholds keep the closest sample.
      if (rb_r && (c_dist < d_rpt)) begin
        rpi_nxt = c_idx;
        rpv_nxt = c_val;
      end
      if (fb_r && (c_dist < d_fpt)) begin
        fpi_nxt = c_idx;
        fpv_nxt = c_val;
      end
      if (!rf_r) begin
        rb_nxt = rb_upd && !xing_i.up_high;
        if (!rb_r && rb_upd) begin
          rpi_nxt = c_idx;
          rpv_nxt = c_val;
        end
        if (xing_i.up_full) begin
          rpi_nxt = cur_idx;
          rpv_nxt = sample_i;
        end
      end
      if (!ff_r) begin
        fb_nxt = fb_upd && !xing_i.dn_low;
        if (!fb_r && fb_upd) begin
          fpi_nxt = c_idx;
          fpv_nxt = c_val;
        end
        if (xing_i.dn_full) begin
          fpi_nxt = idx_r;
          fpv_nxt = prev_r;
        end
      end
      if (r_hit) begin
        rf_nxt = 1'b1;
        ff_nxt = 1'b0;
        fb_nxt = 1'b0;
      end
      if (f_hit) begin
        ff_nxt = 1'b1;
        rf_nxt = 1'b0;
        rb_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      have_r <= 1'b0;
      idx_r  <= '0;
      rb_r   <= 1'b0;
      fb_r   <= 1'b0;
      rf_r   <= 1'b0;
      ff_r   <= 1'b0;
      rpi_r  <= '0;
      rpv_r  <= '0;
      fpi_r  <= '0;
      fpv_r  <= '0;
    end else if (step_i) begin
      prev_r <= prev_nxt;
      have_r <= have_nxt;
      idx_r  <= idx_nxt;
      rb_r   <= rb_nxt;
      fb_r   <= fb_nxt;
      rf_r   <= rf_nxt;
      ff_r   <= ff_nxt;
      rpi_r  <= rpi_nxt;
      rpv_r  <= rpv_nxt;
      fpi_r  <= fpi_nxt;
      fpv_r  <= fpv_nxt;
    end
  end

  assign prev_o       = prev_r;
  assign hit_o        = !restart && (r_hit || f_hit);
  assign rising_o     = r_hit;
  assign edge_index_o = r_hit ? rpi_nxt : fpi_nxt;
  assign edge_value_o = r_hit ? rpv_nxt : fpv_nxt;

endmodule
